>>> hw/rtl/lad_pkg.sv
// Shared constants, widths and operation codes for the linear array deque.
`timescale 1ns / 1ps

package lad_pkg;

  // field widths
  localparam int DATA_W  = 32;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 4;
  localparam int CAP_W   = 4;

  // configuration port
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam logic CAP_REG_IDX = 1'b0;  // word index of capacity_in_use

  localparam int           DEPTH_DEF = 8;
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_REAR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DEL_FRONT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEL_REAR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REPLACE   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ_ALL  = 3'd5;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

endpackage

>>> hw/rtl/lad_cfg.sv
// Capacity register behind the APB port, with its clamped effective value.
`timescale 1ns / 1ps

module lad_cfg #(
  parameter int DEPTH = lad_pkg::DEPTH_DEF,
  localparam int EW   = $clog2(DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lad_pkg::APB_AW-1:0] paddr,
  input  logic [lad_pkg::APB_DW-1:0] pwdata,
  output logic [lad_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output logic [EW-1:0]              eff_cap_o
);

  localparam int CMPW = (EW > lad_pkg::CAP_W) ? EW : lad_pkg::CAP_W;

  logic [lad_pkg::CAP_W-1:0] cap_q, cap_d;
  logic                      hit;
  logic [CMPW-1:0]           cap_ext;
  logic [CMPW-1:0]           clamp;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == lad_pkg::CAP_REG_IDX);

  always_comb begin
    cap_d = cap_q;
    if (psel && penable && pwrite && hit) begin
      cap_d = pwdata[lad_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lad_pkg::CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  assign prdata = hit ? lad_pkg::APB_DW'(cap_q) : '0;

  // zero acts as one, anything above the array size as the array size
  assign cap_ext = CMPW'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      clamp = CMPW'(1);
    end else if (cap_ext > CMPW'(DEPTH)) begin
      clamp = CMPW'(DEPTH);
    end else begin
      clamp = cap_ext;
    end
  end

  assign eff_cap_o = clamp[EW-1:0];

endmodule

>>> hw/rtl/linear_array_deque.sv
// Top level: double-ended queue kept in a linear slot memory.
`timescale 1ns / 1ps

// Channel   | Dir | Handshake               | Payload
// s_axis    | in  | tvalid/tready           | tuser kind, tdata value, new_value
// m_axis    | out | tvalid/tready, tlast    | tuser status, tdata data, replaced_count
// apb       | in  | psel/penable, pready=1  | capacity_in_use at byte address 0
//
// Insert or delete: accept, then execute on the word read at accept. Replace and
// read-all walk the n stored entries one entry a cycle through the single read port
// of the slot memory; a read-all step waits while the output register is still full.
// Reset clears pointers, empty flag and output valid; slot contents stay undefined.
// A waiting result does not block a new beat; execute, walk and done hold only when
// they must emit and the output register is still full.

module linear_array_deque #(
  parameter int DEPTH = lad_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [63:0]                s_axis_tdata,  // [31:0] value, [63:32] new_value
  input  logic [2:0]                 s_axis_tuser,  // [2:0] kind
  // result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [39:0]                m_axis_tdata,  // [31:0] data, [35:32] replaced_count
  output logic [1:0]                 m_axis_tuser,  // [1:0] status
  output logic                       m_axis_tlast,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lad_pkg::APB_AW-1:0] paddr,
  input  logic [lad_pkg::APB_DW-1:0] pwdata,
  output logic [lad_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  localparam int IW = $clog2(DEPTH);
  localparam int EW = $clog2(DEPTH + 1);
  localparam int DW = lad_pkg::DATA_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WALK = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // queue control
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic          empty_q, empty_d;

  // item being worked on
  logic [lad_pkg::KIND_W-1:0] kind_q, kind_d;
  logic [DW-1:0]              val_q, val_d;
  logic [DW-1:0]              nval_q, nval_d;
  logic [IW-1:0]              ptr_q, ptr_d;
  logic [lad_pkg::CNT_W-1:0]  cnt_q, cnt_d;

  // slot memory, one write and one registered read per cycle
  logic [DW-1:0] slots_q [DEPTH];
  logic [DW-1:0] rd_data_q;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic [lad_pkg::STAT_W-1:0] out_stat_q;
  logic [DW-1:0]              out_data_q;
  logic [lad_pkg::CNT_W-1:0]  out_cnt_q;
  logic                       out_last_q;

  // result offered by the sequencer this cycle
  logic                       emit, fire, out_free, in_fire;
  logic [lad_pkg::STAT_W-1:0] res_stat;
  logic [DW-1:0]              res_data;
  logic [lad_pkg::CNT_W-1:0]  res_cnt;
  logic                       res_last;

  logic [EW-1:0] eff_cap;
  logic          rear_full;
  logic          last_entry;
  logic          step;

  lad_cfg #(
    .DEPTH (DEPTH)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .eff_cap_o (eff_cap)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = emit && out_free;

  // tail is full once it sits at or past the last slot in use
  assign rear_full  = (EW'(tail_q) + EW'(1)) >= eff_cap;
  assign last_entry = (ptr_q == tail_q);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    empty_d   = empty_q;
    kind_d    = kind_q;
    val_d     = val_q;
    nval_d    = nval_q;
    ptr_d     = ptr_q;
    cnt_d     = cnt_q;
    rd_en     = 1'b0;
    rd_addr   = head_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = nval_q;
    emit      = 1'b0;
    res_stat  = lad_pkg::STAT_OK;
    res_data  = '0;
    res_cnt   = '0;
    res_last  = 1'b1;
    step      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          kind_d  = s_axis_tuser;
          val_d   = s_axis_tdata[31:0];
          nval_d  = s_axis_tdata[63:32];
          ptr_d   = head_q;
          cnt_d   = '0;
          // prefetch the word a delete or walk will need
          rd_en   = 1'b1;
          rd_addr = (s_axis_tuser == lad_pkg::KIND_DEL_REAR) ? tail_q : head_q;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        case (kind_q)
          lad_pkg::KIND_INS_FRONT: begin
            emit = 1'b1;
            if (!empty_q && head_q == '0) begin
              res_stat = lad_pkg::STAT_FULL;
            end
            if (fire) begin
              state_d   = S_IDLE;
              mem_wdata = val_q;
              if (empty_q) begin
                empty_d   = 1'b0;
                mem_we    = 1'b1;
                mem_waddr = '0;
              end else if (head_q != '0) begin
                head_d    = head_q - IW'(1);
                mem_we    = 1'b1;
                mem_waddr = head_q - IW'(1);
              end
            end
          end

          lad_pkg::KIND_INS_REAR: begin
            emit = 1'b1;
            if (!empty_q && rear_full) begin
              res_stat = lad_pkg::STAT_FULL;
            end
            if (fire) begin
              state_d   = S_IDLE;
              mem_wdata = val_q;
              if (empty_q) begin
                empty_d   = 1'b0;
                mem_we    = 1'b1;
                mem_waddr = '0;
              end else if (!rear_full) begin
                tail_d    = tail_q + IW'(1);
                mem_we    = 1'b1;
                mem_waddr = tail_q + IW'(1);
              end
            end
          end

          lad_pkg::KIND_DEL_FRONT, lad_pkg::KIND_DEL_REAR: begin
            emit = 1'b1;
            if (empty_q) begin
              res_stat = lad_pkg::STAT_EMPTY;
            end else begin
              res_data = rd_data_q;
            end
            if (fire) begin
              state_d = S_IDLE;
              if (!empty_q) begin
                if (head_q == tail_q) begin
                  // last entry gone: back to the empty layout
                  head_d  = '0;
                  tail_d  = '0;
                  empty_d = 1'b1;
                end else if (kind_q == lad_pkg::KIND_DEL_FRONT) begin
                  head_d = head_q + IW'(1);
                end else begin
                  tail_d = tail_q - IW'(1);
                end
              end
            end
          end

          lad_pkg::KIND_REPLACE, lad_pkg::KIND_READ_ALL: begin
            if (empty_q) begin
              emit     = 1'b1;
              res_stat = lad_pkg::STAT_EMPTY;
              if (fire) begin
                state_d = S_IDLE;
              end
            end else begin
              state_d = S_WALK;
            end
          end

          default: begin
            // unused kinds: no result, no change
            state_d = S_IDLE;
          end
        endcase
      end

      S_WALK: begin
        if (kind_q == lad_pkg::KIND_READ_ALL) begin
          emit     = 1'b1;
          res_data = rd_data_q;
          res_last = last_entry;
          step     = fire;
        end else begin
          step = 1'b1;
          if (rd_data_q == val_q) begin
            mem_we    = 1'b1;
            mem_waddr = ptr_q;
            mem_wdata = nval_q;
            if (cnt_q != '1) begin
              cnt_d = cnt_q + lad_pkg::CNT_W'(1);
            end
          end
        end
        if (step) begin
          if (last_entry) begin
            state_d = (kind_q == lad_pkg::KIND_READ_ALL) ? S_IDLE : S_DONE;
          end else begin
            // write goes to ptr, read to ptr + 1: never the same slot
            ptr_d   = ptr_q + IW'(1);
            rd_en   = 1'b1;
            rd_addr = ptr_q + IW'(1);
          end
        end
      end

      S_DONE: begin
        emit     = 1'b1;
        res_stat = (cnt_q != '0) ? lad_pkg::STAT_OK : lad_pkg::STAT_NOT_FOUND;
        res_cnt  = cnt_q;
        if (fire) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    val_q  <= val_d;
    nval_q <= nval_d;
    ptr_q  <= ptr_d;
    cnt_q  <= cnt_d;
    if (fire) begin
      out_stat_q <= res_stat;
      out_data_q <= res_data;
      out_cnt_q  <= res_cnt;
      out_last_q <= res_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slots_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= slots_q[rd_addr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_cnt_q, out_data_q};
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tlast  = out_last_q;

  // an empty queue always sits at slot 0
  a_empty_home : assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (head_q == '0 && tail_q == '0))
    else $error("empty queue with pointers away from slot 0");

  a_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_q |-> (head_q <= tail_q))
    else $error("head past tail");

  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == S_EXEC))
    else $error("accepted beat did not reach execute");

  a_walk_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (ptr_q >= head_q && ptr_q <= tail_q && !empty_q))
    else $error("walk pointer outside stored range");

endmodule

>>> sim/linear_array_deque_checker.sv
// Scoreboard for the linear array deque: mirrors its state and checks every result beat.
`timescale 1ns / 1ps

module linear_array_deque_checker
  import lad_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [63:0]       s_tdata_i,   // [31:0] value, [63:32] new_value
  input  logic [2:0]        s_tuser_i,   // [2:0] kind
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [39:0]       m_tdata_i,   // [31:0] data, [35:32] replaced_count
  input  logic [1:0]        m_tuser_i,   // [1:0] status
  input  logic              m_tlast_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  input  logic [APB_DW-1:0] prdata_i,
  output int                mismatch_count_o,
  output int                results_left_o,
  output int                beats_checked_o
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
    logic              last;
  } deque_result_t;

  deque_result_t     pending_results[$];
  logic [DATA_W-1:0] slot_mem [DEPTH];
  int unsigned       head_idx;
  int unsigned       tail_idx;
  logic              queue_empty;
  logic [CAP_W-1:0]  capacity;

  // 0 behaves as 1, anything above DEPTH as DEPTH
  function automatic int unsigned usable_slots();
    int unsigned c;
    c = capacity;
    if (c == 0) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic void push_result(logic [STAT_W-1:0] st, logic [DATA_W-1:0] d,
                                      logic [CNT_W-1:0] n, logic lst);
    deque_result_t r;
    r.status = st;
    r.data   = d;
    r.count  = n;
    r.last   = lst;
    pending_results.push_back(r);
  endfunction

  // removing the only entry returns both indices to slot 0
  function automatic logic [DATA_W-1:0] take_entry(logic at_head);
    logic [DATA_W-1:0] v;
    if (head_idx == tail_idx) begin
      v = slot_mem[head_idx];
      head_idx = 0;
      tail_idx = 0;
      queue_empty = 1'b1;
    end else if (at_head) begin
      v = slot_mem[head_idx];
      head_idx++;
    end else begin
      v = slot_mem[tail_idx];
      tail_idx--;
    end
    return v;
  endfunction

  function automatic void apply_deque_op(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] key,
                                         logic [DATA_W-1:0] repl);
    int unsigned hits;
    hits = 0;
    case (kind)
      KIND_INS_FRONT: begin
        if (queue_empty) begin
          head_idx = 0;
          tail_idx = 0;
          queue_empty = 1'b0;
          slot_mem[0] = key;
          push_result(STAT_OK, '0, '0, 1'b1);
        end else if (head_idx == 0) begin
          push_result(STAT_FULL, '0, '0, 1'b1);
        end else begin
          head_idx--;
          slot_mem[head_idx] = key;
          push_result(STAT_OK, '0, '0, 1'b1);
        end
      end
      KIND_INS_REAR: begin
        if (queue_empty) begin
          head_idx = 0;
          tail_idx = 0;
          queue_empty = 1'b0;
          slot_mem[0] = key;
          push_result(STAT_OK, '0, '0, 1'b1);
        end else if (tail_idx >= usable_slots() - 1) begin
          push_result(STAT_FULL, '0, '0, 1'b1);
        end else begin
          tail_idx++;
          slot_mem[tail_idx] = key;
          push_result(STAT_OK, '0, '0, 1'b1);
        end
      end
      KIND_DEL_FRONT, KIND_DEL_REAR: begin
        if (queue_empty) push_result(STAT_EMPTY, '0, '0, 1'b1);
        else push_result(STAT_OK, take_entry(kind == KIND_DEL_FRONT), '0, 1'b1);
      end
      KIND_REPLACE: begin
        if (queue_empty) begin
          push_result(STAT_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int unsigned i = head_idx; i <= tail_idx && i < DEPTH; i++) begin
            if (slot_mem[i] == key) begin
              slot_mem[i] = repl;
              if (hits < 15) hits++;
            end
          end
          push_result((hits != 0) ? STAT_OK : STAT_NOT_FOUND, '0, CNT_W'(hits), 1'b1);
        end
      end
      KIND_READ_ALL: begin
        if (queue_empty) begin
          push_result(STAT_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int unsigned i = head_idx; i <= tail_idx && i < DEPTH; i++)
            push_result(STAT_OK, slot_mem[i], '0, i == tail_idx);
        end
      end
      default: ;  // spare kinds leave everything untouched
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    mismatch_count_o++;
    if (mismatch_count_o <= 50)
      $display("[%0t] beat %0d: %s expected %h got %h", $time, beats_checked_o, what, want, got);
  endtask

  task automatic check_result_beat();
    deque_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("beat with nothing expected, data", '0, m_tdata_i[DATA_W-1:0]);
    end else begin
      want = pending_results.pop_front();
      if (m_tuser_i != want.status) report_mismatch("status", want.status, m_tuser_i);
      if (m_tdata_i[DATA_W-1:0] != want.data)
        report_mismatch("data", want.data, m_tdata_i[DATA_W-1:0]);
      if (m_tdata_i[DATA_W +: CNT_W] != want.count)
        report_mismatch("replaced_count", want.count, m_tdata_i[DATA_W +: CNT_W]);
      if (m_tlast_i != want.last) report_mismatch("last", want.last, m_tlast_i);
    end
    beats_checked_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_results.delete();
      for (int i = 0; i < DEPTH; i++) slot_mem[i] = '0;
      head_idx         = 0;
      tail_idx         = 0;
      queue_empty      = 1'b1;
      capacity         = CAP_RESET;
      mismatch_count_o = 0;
      results_left_o   = 0;
      beats_checked_o  = 0;
    end else begin
      // a result can never stem from the beat taken at the same edge
      if (m_tvalid_i && m_tready_i) check_result_beat();
      if (s_tvalid_i && s_tready_i)
        apply_deque_op(s_tuser_i, s_tdata_i[DATA_W-1:0], s_tdata_i[2*DATA_W-1:DATA_W]);
      if (psel_i && penable_i && pready_i && paddr_i[APB_AW-1:2] == CAP_REG_IDX) begin
        if (pwrite_i) capacity = pwdata_i[CAP_W-1:0];
        else if (prdata_i != APB_DW'(capacity))
          report_mismatch("capacity readback", APB_DW'(capacity), prdata_i);
      end
      results_left_o = pending_results.size();
    end
  end

endmodule

>>> sim/tb_linear_array_deque.sv
// Testbench top for the linear array deque: stimulus, flow control, timeout and verdict.
`timescale 1ns / 1ps

module tb_linear_array_deque;
  import lad_pkg::*;

  localparam int          HOLD_CYCLES  = 150;     // long receiver hold-off
  localparam int          QUIET_CYCLES = 24;      // covers the longest walk plus margin
  localparam longint      TIMEOUT_NS   = 4_000_000;
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;  // unused codes, must be ignored
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;
  localparam logic [APB_AW-1:0] CAP_ADDR     = {CAP_REG_IDX, 2'b00};

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata  = '0;   // [31:0] value, [63:32] new_value
  logic [2:0]          s_axis_tuser  = '0;   // [2:0] kind
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [39:0]         m_axis_tdata;         // [31:0] data, [35:32] replaced_count
  logic [1:0]          m_axis_tuser;         // [1:0] status
  logic                m_axis_tlast;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [APB_AW-1:0]   paddr         = '0;
  logic [APB_DW-1:0]   pwdata        = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int                  mismatches;
  int                  results_left;
  int                  beats_checked;

  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  logic                hold_req      = 1'b0;
  int                  hold_left     = 0;
  int                  ops_sent      = 0;
  int                  hold_offs     = 0;
  logic [DATA_W-1:0]   value_pool [4];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  linear_array_deque i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  linear_array_deque_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tuser_i        (s_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tuser_i        (m_axis_tuser),
    .m_tlast_i        (m_axis_tlast),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .prdata_i         (prdata),
    .mismatch_count_o (mismatches),
    .results_left_o   (results_left),
    .beats_checked_o  (beats_checked)
  );

  // Result side: random back-pressure, or a long hold-off once hold_req is seen.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_req) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[linear_array_deque] ERROR");
    $finish;
  end

  // Mostly corner values and a small pool, so replace finds its keys often.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:          return 32'h8000_0000;
      1:          return 32'h7fff_ffff;
      2:          return '0;
      3:          return '1;
      4, 5, 6, 7: return value_pool[$urandom_range(3)];
      default:    return $urandom();
    endcase
  endfunction

  task automatic send_op(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] val,
                         logic [DATA_W-1:0] nval);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {nval, val};
    do @(posedge clk_i); while (!s_axis_tready);
    ops_sent++;
  endtask

  // Sender stops until every predicted beat has come back, then lets the block settle.
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (results_left == 0);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(logic wr, logic [APB_AW-1:0] addr, logic [APB_DW-1:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Upper data bits carry junk; only the low nibble is the register.
  task automatic set_capacity(logic [CAP_W-1:0] cap);
    logic [APB_DW-1:0] wdata;
    wdata = $urandom();
    wdata[CAP_W-1:0] = cap;
    apb_access(1'b1, CAP_ADDR, wdata);
    apb_access(1'b0, CAP_ADDR, '0);
  endtask

  // Spare kinds are mixed in but do not count towards the total.
  task automatic random_ops(int count);
    int                done;
    int                r;
    logic [KIND_W-1:0] kind;
    done = 0;
    while (done < count) begin
      r = $urandom_range(99);
      if (r < 24)      kind = KIND_INS_REAR;
      else if (r < 42) kind = KIND_INS_FRONT;
      else if (r < 58) kind = KIND_DEL_FRONT;
      else if (r < 72) kind = KIND_DEL_REAR;
      else if (r < 84) kind = KIND_REPLACE;
      else if (r < 96) kind = KIND_READ_ALL;
      else             kind = $urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B;
      send_op(kind, pick_value(), pick_value());
      if (kind != KIND_SPARE_A && kind != KIND_SPARE_B) done++;
    end
  endtask

  // Receiver freezes while the sender pushes flat out, so the input must stall.
  task automatic hold_off_burst();
    int saved_pct;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    hold_offs++;
    random_ops(20);
    send_idle_pct = saved_pct;
  endtask

  // Empty queue cases, head refused at slot 0, rear filled to the last slot and
  // refused, full read-out, replace hit and miss, spare kinds.
  task automatic directed_ops();
    send_op(KIND_DEL_FRONT, '0, '0);
    send_op(KIND_DEL_REAR,  '0, '0);
    send_op(KIND_REPLACE,   32'h0000_0005, 32'h1111_1111);
    send_op(KIND_READ_ALL,  '0, '0);
    send_op(KIND_INS_FRONT, 32'h7fff_ffff, '0);
    send_op(KIND_INS_FRONT, 32'h0000_0001, '0);
    send_op(KIND_INS_REAR,  32'h8000_0000, '0);
    send_op(KIND_INS_REAR,  32'h0000_0000, '0);
    send_op(KIND_INS_REAR,  32'hffff_ffff, '0);
    send_op(KIND_INS_REAR,  32'h0000_0005, '0);
    send_op(KIND_INS_REAR,  32'h0000_0005, '0);
    send_op(KIND_INS_REAR,  32'haaaa_aaaa, '0);
    send_op(KIND_INS_REAR,  32'h5555_5555, '0);
    send_op(KIND_INS_REAR,  32'h1234_5678, '0);
    send_op(KIND_READ_ALL,  '0, '0);
    send_op(KIND_REPLACE,   32'h0000_0005, 32'hffff_ffff);
    send_op(KIND_REPLACE,   32'h0bad_cafe, 32'h0000_0000);
    send_op(KIND_DEL_FRONT, '0, '0);
    send_op(KIND_INS_FRONT, 32'h8000_0000, '0);
    send_op(KIND_DEL_REAR,  '0, '0);
    send_op(KIND_SPARE_A,   32'hffff_ffff, 32'hffff_ffff);
    send_op(KIND_SPARE_B,   32'h0000_0000, 32'h0000_0000);
  endtask

  initial begin
    for (int i = 0; i < 4; i++) value_pool[i] = $urandom();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(1'b0, CAP_ADDR, '0);  // reset value of the capacity register

    // sender idles lightly, receiver heavily
    send_idle_pct = 22;
    recv_idle_pct = 54;
    directed_ops();
    wait_quiet();
    random_ops(40);
    hold_off_burst();
    random_ops(40);
    wait_quiet();
    set_capacity(4'd3);  // usually below the occupied range here
    random_ops(70);
    wait_quiet();

    // swap the roles
    send_idle_pct = 54;
    recv_idle_pct = 22;
    set_capacity(4'd0);
    random_ops(50);
    wait_quiet();
    set_capacity(4'd15);
    random_ops(70);
    wait_quiet();

    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_capacity(4'd1);
    random_ops(40);
    wait_quiet();
    set_capacity(4'd8);
    random_ops(30);
    hold_off_burst();
    random_ops(40);
    wait_quiet();

    $display("Run covered %0d operations over capacities 8, 3, 0, 15, 1 and 8 again,",
             ops_sent);
    $display("with three idling patterns, %0d receiver hold-offs and %0d beats checked.",
             hold_offs, beats_checked);
    if (mismatches == 0) begin
      $display("[linear_array_deque] OK");
    end else begin
      $display("[linear_array_deque] ERROR");
    end
    $finish;
  end

endmodule
